// ----- design/tcdc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcdc_pkg: shared types and helpers for the two-channel dimmer control
// Holds the event kind codes, the register index codes, the mode state type,
// the configuration and result bundles and the level arithmetic.
// ----------------------------------------------------------------------------
package tcdc_pkg;

   // event kinds on the request side
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_BUTTON  = 2'd1;
   localparam logic [1:0] KIND_ENCODER = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_MAX_LEVEL      = 3'd0;
   localparam logic [2:0] CSR_MIN_LEVEL      = 3'd1;
   localparam logic [2:0] CSR_FINE_STEP      = 3'd2;
   localparam logic [2:0] CSR_COARSE_STEP    = 3'd3;
   localparam logic [2:0] CSR_FLASH_TOGGLES  = 3'd4;
   localparam logic [2:0] CSR_HALF_PERIOD    = 3'd5;
   localparam logic [2:0] CSR_STORED_LEVEL_A = 3'd6;
   localparam logic [2:0] CSR_STORED_LEVEL_B = 3'd7;

   // register reset values
   localparam logic [7:0]  RST_MAX_LEVEL     = 8'd255;
   localparam logic [7:0]  RST_MIN_LEVEL     = 8'd1;
   localparam logic [6:0]  RST_FINE_STEP     = 7'd1;
   localparam logic [6:0]  RST_COARSE_STEP   = 7'd8;
   localparam logic [6:0]  RST_FLASH_TOGGLES = 7'd3;
   localparam logic [15:0] RST_HALF_PERIOD   = 16'd250;

   // level arithmetic constants
   localparam logic [8:0] COARSE_ZONE   = 9'd64;
   localparam logic [7:0] DEFAULT_LEVEL = 8'd16;
   localparam logic [7:0] BLANK_LEVEL   = 8'hFF;

   // reported mode codes
   localparam logic [2:0] CODE_OFF      = 3'd0;
   localparam logic [2:0] CODE_A        = 3'd1;
   localparam logic [2:0] CODE_A_FLASH  = 3'd2;
   localparam logic [2:0] CODE_B        = 3'd3;
   localparam logic [2:0] CODE_B_FLASH  = 3'd4;
   localparam logic [2:0] CODE_AB       = 3'd5;
   localparam logic [2:0] CODE_AB_FLASH = 3'd6;

   // operating mode, one-hot
   typedef enum logic [6:0] {
      MODE_OFF      = 7'b0000001,
      MODE_A        = 7'b0000010,
      MODE_A_FLASH  = 7'b0000100,
      MODE_B        = 7'b0001000,
      MODE_B_FLASH  = 7'b0010000,
      MODE_AB       = 7'b0100000,
      MODE_AB_FLASH = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [7:0]  max_level;
      logic [7:0]  min_level;
      logic [6:0]  fine_step;
      logic [6:0]  coarse_step;
      logic [6:0]  flash_toggles;
      logic [15:0] half_period;
   } cfg_type;

   // level load from a stored level register write
   typedef struct packed {
      logic       load_a;
      logic       load_b;
      logic [7:0] level;
   } load_type;

   typedef struct packed {
      logic [2:0] mode_now;
      logic [1:0] save_request;
      logic       enable_b;
      logic       enable_a;
      logic [7:0] level_b;
      logic [7:0] level_a;
   } rsp_type;

   // a blank or zero stored level falls back to the default
   function automatic logic [7:0] fix_stored(input logic [7:0] v);
      fix_stored = (v == 8'd0 || v == BLANK_LEVEL) ? DEFAULT_LEVEL : v;
   endfunction

   // one encoder step with saturation at the limits
   function automatic logic [7:0] encoder_move(input logic [7:0] level,
                                               input logic       up,
                                               input cfg_type    cfg);
      logic [6:0] step;
      logic [8:0] sum;
      logic [8:0] floor_lvl;
      step      = (({1'b0, level} + COARSE_ZONE) > {1'b0, cfg.max_level}) ?
                  cfg.coarse_step : cfg.fine_step;
      sum       = {1'b0, level} + {2'b0, step};
      floor_lvl = {1'b0, cfg.min_level} + {2'b0, step};
      if (up) begin
         encoder_move = (sum >= {1'b0, cfg.max_level}) ? cfg.max_level : sum[7:0];
      end else begin
         encoder_move = ({1'b0, level} < floor_lvl) ? cfg.min_level :
                        (level - {1'b0, step});
      end
   endfunction

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      c = CODE_OFF;
      unique case (m)
         MODE_OFF:      c = CODE_OFF;
         MODE_A:        c = CODE_A;
         MODE_A_FLASH:  c = CODE_A_FLASH;
         MODE_B:        c = CODE_B;
         MODE_B_FLASH:  c = CODE_B_FLASH;
         MODE_AB:       c = CODE_AB;
         MODE_AB_FLASH: c = CODE_AB_FLASH;
         default:       c = CODE_OFF;
      endcase
      mode_code = c;
   endfunction

endpackage

// ----- design/tcdc_csr.sv -----
// ----------------------------------------------------------------------------
// tcdc_csr: configuration registers
// Holds the limit, step and flash timing registers and turns writes of the
// stored levels into level loads for the control core.
// ----------------------------------------------------------------------------
module tcdc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [2:0]          wr_index,
   input  logic [15:0]         wr_data,
   output tcdc_pkg::cfg_type   cfg,
   output tcdc_pkg::load_type  load
);

   tcdc_pkg::cfg_type cfg_ff;
   tcdc_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            tcdc_pkg::CSR_MAX_LEVEL:     cfg_in.max_level     = wr_data[7:0];
            tcdc_pkg::CSR_MIN_LEVEL:     cfg_in.min_level     = wr_data[7:0];
            tcdc_pkg::CSR_FINE_STEP:     cfg_in.fine_step     = wr_data[6:0];
            tcdc_pkg::CSR_COARSE_STEP:   cfg_in.coarse_step   = wr_data[6:0];
            tcdc_pkg::CSR_FLASH_TOGGLES: cfg_in.flash_toggles = wr_data[6:0];
            tcdc_pkg::CSR_HALF_PERIOD:   cfg_in.half_period   = wr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_level     <= tcdc_pkg::RST_MAX_LEVEL;
         cfg_ff.min_level     <= tcdc_pkg::RST_MIN_LEVEL;
         cfg_ff.fine_step     <= tcdc_pkg::RST_FINE_STEP;
         cfg_ff.coarse_step   <= tcdc_pkg::RST_COARSE_STEP;
         cfg_ff.flash_toggles <= tcdc_pkg::RST_FLASH_TOGGLES;
         cfg_ff.half_period   <= tcdc_pkg::RST_HALF_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stored level writes load the channel level right away
   always_comb begin
      load.load_a = wr_en && (wr_index == tcdc_pkg::CSR_STORED_LEVEL_A);
      load.load_b = wr_en && (wr_index == tcdc_pkg::CSR_STORED_LEVEL_B);
      load.level  = tcdc_pkg::fix_stored(wr_data[7:0]);
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/tcdc_core.sv -----
// ----------------------------------------------------------------------------
// tcdc_core: dimmer control state
// Keeps mode, levels, on flags, flash countdown and tick timer, applies one
// event per cycle while step_en is high and presents the state after the event.
// ----------------------------------------------------------------------------
module tcdc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [1:0]          kind,
   input  logic                long_press,
   input  logic                turn_up,
   input  tcdc_pkg::cfg_type   cfg,
   input  tcdc_pkg::load_type  load,
   output tcdc_pkg::rsp_type   rsp
);

   tcdc_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  level_a_ff, level_a_in;
   logic [7:0]  level_b_ff, level_b_in;
   logic        on_a_ff, on_a_in;
   logic        on_b_ff, on_b_in;
   logic [7:0]  flashes_ff, flashes_in;
   logic [15:0] tick_ff, tick_in;
   logic [1:0]  save;
   logic [7:0]  flash_start;

   assign flash_start = {cfg.flash_toggles, 1'b0};

   // event handling
   always_comb begin
      mode_in    = mode_ff;
      level_a_in = level_a_ff;
      level_b_in = level_b_ff;
      on_a_in    = on_a_ff;
      on_b_in    = on_b_ff;
      flashes_in = flashes_ff;
      tick_in    = tick_ff;
      save       = 2'd0;
      if (step_en) begin
         unique case (kind)
            tcdc_pkg::KIND_TICK: begin
               tick_in = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;
               if (tick_in > cfg.half_period &&
                   (mode_ff == tcdc_pkg::MODE_A_FLASH ||
                    mode_ff == tcdc_pkg::MODE_B_FLASH ||
                    mode_ff == tcdc_pkg::MODE_AB_FLASH)) begin
                  flashes_in = flashes_ff - 8'd1;
                  if (flashes_in == 8'd0) begin
                     // flash sequence over: channel back on, steady mode
                     unique case (mode_ff)
                        tcdc_pkg::MODE_A_FLASH: begin
                           on_a_in = 1'b1;
                           mode_in = tcdc_pkg::MODE_A;
                        end
                        tcdc_pkg::MODE_B_FLASH: begin
                           on_b_in = 1'b1;
                           mode_in = tcdc_pkg::MODE_B;
                        end
                        default: begin
                           on_a_in = 1'b1;
                           on_b_in = 1'b1;
                           mode_in = tcdc_pkg::MODE_AB;
                        end
                     endcase
                  end else begin
                     // toggle the flashing channels, restart half period
                     if (mode_ff != tcdc_pkg::MODE_B_FLASH) on_a_in = ~on_a_ff;
                     if (mode_ff != tcdc_pkg::MODE_A_FLASH) on_b_in = ~on_b_ff;
                     tick_in = 16'd0;
                  end
               end
            end
            tcdc_pkg::KIND_BUTTON: begin
               unique case (mode_ff)
                  tcdc_pkg::MODE_OFF: begin
                     on_a_in = 1'b1;
                     tick_in = 16'd0;
                     if (long_press) begin
                        on_b_in = 1'b1;
                        mode_in = tcdc_pkg::MODE_AB;
                     end else begin
                        mode_in = tcdc_pkg::MODE_A;
                     end
                  end
                  tcdc_pkg::MODE_A: begin
                     tick_in = 16'd0;
                     if (long_press) begin
                        save       = 2'd1;
                        flashes_in = flash_start;
                        mode_in    = tcdc_pkg::MODE_A_FLASH;
                     end else begin
                        on_a_in = 1'b0;
                        on_b_in = 1'b1;
                        mode_in = tcdc_pkg::MODE_B;
                     end
                  end
                  tcdc_pkg::MODE_B: begin
                     tick_in = 16'd0;
                     if (long_press) begin
                        save       = 2'd2;
                        flashes_in = flash_start;
                        mode_in    = tcdc_pkg::MODE_B_FLASH;
                     end else begin
                        on_a_in = 1'b1;
                        on_b_in = 1'b1;
                        mode_in = tcdc_pkg::MODE_AB;
                     end
                  end
                  tcdc_pkg::MODE_AB: begin
                     tick_in = 16'd0;
                     if (long_press) begin
                        save       = 2'd3;
                        flashes_in = flash_start;
                        mode_in    = tcdc_pkg::MODE_AB_FLASH;
                     end else begin
                        on_a_in = 1'b0;
                        on_b_in = 1'b0;
                        mode_in = tcdc_pkg::MODE_OFF;
                     end
                  end
                  // presses while flashing are ignored
                  default: mode_in = mode_ff;
               endcase
            end
            tcdc_pkg::KIND_ENCODER: begin
               if (mode_ff == tcdc_pkg::MODE_A) begin
                  level_a_in = tcdc_pkg::encoder_move(level_a_ff, turn_up, cfg);
               end else if (mode_ff == tcdc_pkg::MODE_B) begin
                  level_b_in = tcdc_pkg::encoder_move(level_b_ff, turn_up, cfg);
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
      // stored level writes
      if (load.load_a) level_a_in = load.level;
      if (load.load_b) level_b_in = load.level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= tcdc_pkg::MODE_OFF;
         level_a_ff <= tcdc_pkg::DEFAULT_LEVEL;
         level_b_ff <= tcdc_pkg::DEFAULT_LEVEL;
         on_a_ff    <= 1'b0;
         on_b_ff    <= 1'b0;
         flashes_ff <= 8'd0;
         tick_ff    <= 16'd0;
      end else begin
         mode_ff    <= mode_in;
         level_a_ff <= level_a_in;
         level_b_ff <= level_b_in;
         on_a_ff    <= on_a_in;
         on_b_ff    <= on_b_in;
         flashes_ff <= flashes_in;
         tick_ff    <= tick_in;
      end
   end

   // state after the event
   always_comb begin
      rsp.level_a      = level_a_in;
      rsp.level_b      = level_b_in;
      rsp.enable_a     = on_a_in;
      rsp.enable_b     = on_b_in;
      rsp.save_request = save;
      rsp.mode_now     = tcdc_pkg::mode_code(mode_in);
   end

endmodule

// ----- design/two_channel_dimmer_control_top.sv -----
// ----------------------------------------------------------------------------
// two_channel_dimmer_control_top: two-channel dimmer controller
// Request stream of tick, button and encoder events; one status word out per
// event with both levels, on flags, save request and current mode.
//
// Usage:
//   req_ channel carries one event word: tuser is the event kind, tdata the
//   press length and encoder direction. rsp_ channel returns one word per
//   event with the state after that event. csr_ channel writes the six
//   configuration registers; it is always ready and should be used only
//   while no event is in flight. Writing a stored level index loads that
//   channel's level (zero or 255 load 16).
//   After the accepting edge the event waits in the input register; once the
//   result register is free, the control state and the result register are
//   written at the same edge. One event per cycle is taken while the receiver
//   keeps up; the rate is set by the single state update per event.
//   Reset puts all channels off, levels at 16 and registers at defaults.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; req_tready falls until rsp_tready returns.
// ----------------------------------------------------------------------------
module two_channel_dimmer_control_top (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // long_press [0], turn_up [1], zero [7:2]
   input  logic [1:0]  req_tuser,   // event kind [1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // level_a [7:0], level_b [15:8],
                                    // enable_a [16], enable_b [17],
                                    // save_request [19:18], mode_now [22:20],
                                    // zero [23]
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        kind_ff;
   logic              long_ff;
   logic              up_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tcdc_pkg::rsp_type rsp_ff;
   tcdc_pkg::rsp_type rsp_next;
   logic              advance;
   logic              req_take;

   tcdc_pkg::cfg_type  cfg;
   tcdc_pkg::load_type load;

   assign csr_ready = 1'b1;

   tcdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg),
      .load     (load)
   );

   // pipeline handshake
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_tuser;
         long_ff <= req_tdata[0];
         up_ff   <= req_tdata[1];
      end
   end

   tcdc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .kind       (kind_ff),
      .long_press (long_ff),
      .turn_up    (up_ff),
      .cfg        (cfg),
      .load       (load),
      .rsp        (rsp_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

endmodule
